@@ sv/vector_angle_atan2_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the vector angle block
// Shared property forms: same-cycle and next-cycle implication under reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ANGLE_ATAN2_MACROS_SVH
`define VECTOR_ANGLE_ATAN2_MACROS_SVH

// check cons in the same cycle as ante, idle while reset is asserted
`define VAA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante, idle while reset is asserted
`define VAA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/vaa_pkg.sv @@
// ----------------------------------------------------------------------------
// vaa_pkg
// Widths, stage types and the arctangent table of the vector angle pipeline.
// ----------------------------------------------------------------------------
package vaa_pkg;

	localparam int ITERATIONS  = 16;
	localparam int ANGLE_BITS  = 16;
	localparam int TAB_LEN     = 24;
	localparam int STEP_W      = $clog2(TAB_LEN);
	localparam int DEFL_W      = 12;
	localparam int MAG_W       = DEFL_W;
	localparam int MAG_SHIFT   = 20;
	localparam int XY_W        = MAG_W + MAG_SHIFT + 3;
	localparam int Z_W         = 33;
	localparam int ZC_W        = 31;
	localparam int ROUND_SHIFT = 32 - ANGLE_BITS;
	localparam int ANGLE_W     = 16;
	localparam int TDATA_IN_W  = 24;
	localparam int TDATA_OUT_W = 16;

	// clamp limit of the accumulator: a quarter turn in 2^-32 turn units
	localparam logic [ZC_W-1:0] Z_QUARTER  = ZC_W'(64'd1 << 30);
	localparam logic [ZC_W-1:0] ROUND_HALF = ZC_W'(64'd1 << (ROUND_SHIFT - 1));
	localparam logic [ANGLE_BITS-1:0] ANGLE_HALF    = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 1));
	localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 2));

	// quadrant of the vector; on an axis it names the axis (Q1 +x, Q2 +y, Q3 -x, Q4 -y)
	typedef enum logic [1:0] {
		FOLD_Q1 = 2'd0,
		FOLD_Q2 = 2'd1,
		FOLD_Q3 = 2'd2,
		FOLD_Q4 = 2'd3
	} fold_t;

	typedef struct packed {
		logic  axis;
		fold_t fold;
	} route_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		route_t                 route;
	} cordic_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			5'd20:   v = 32'h0000028C;
			5'd21:   v = 32'h00000146;
			5'd22:   v = 32'h000000A3;
			5'd23:   v = 32'h00000051;
			default: v = 32'h00000000;
		endcase
		return signed'(Z_W'(v));
	endfunction

endpackage

@@ sv/vector_angle_atan2.sv @@
// ----------------------------------------------------------------------------
// vector_angle_atan2
// Full-circle direction angle of a signed deflection vector by CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side s_*: one item per (dx, dy) pair, accepted when s_tvalid and
//   s_tready are high at a rising edge of clk. Master side m_*: one angle item
//   per input item, in order, 65536 units per turn counterclockwise from +x.
//   The zero vector gives 0; vectors on an axis give exact quarter turns.
//   Pipeline: a fold stage, one stage per CORDIC micro-rotation, and a
//   rounding and unfold stage that is also the output register.
//   Throughput: one item per cycle while m_tready is high; each
//   micro-rotation has its own adder stage, so no unit is shared between items.
//   Reset: arst_n clears every stage valid bit at once; the block accepts an
//   item in the first cycle after reset is released.
//   Stall: when m_tready is low, items close up behind the output register
//   into empty stages, and s_tready stays high until every stage holds an item.
// ----------------------------------------------------------------------------
`include "vector_angle_atan2_macros.svh"

module vector_angle_atan2 (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [vaa_pkg::TDATA_IN_W-1:0]    s_tdata,   // dx [11:0], dy [23:12]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [vaa_pkg::TDATA_OUT_W-1:0]   m_tdata    // angle [15:0]
);

	logic                 valid_p [vaa_pkg::ITERATIONS+1];
	logic                 ready_p [vaa_pkg::ITERATIONS+1];
	vaa_pkg::cordic_t     data_p  [vaa_pkg::ITERATIONS+1];
	logic [vaa_pkg::ANGLE_W-1:0] angle;

	vaa_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.dx        (signed'(s_tdata[vaa_pkg::DEFL_W-1:0])),
		.dy        (signed'(s_tdata[2*vaa_pkg::DEFL_W-1:vaa_pkg::DEFL_W])),
		.out_valid (valid_p[0]),
		.out_ready (ready_p[0]),
		.out_data  (data_p[0])
	);

	for (genvar i = 0; i < vaa_pkg::ITERATIONS; i++) begin : g_step
		vaa_cordic_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (vaa_pkg::STEP_W'(i)),
			.in_valid  (valid_p[i]),
			.in_ready  (ready_p[i]),
			.in_data   (data_p[i]),
			.out_valid (valid_p[i+1]),
			.out_ready (ready_p[i+1]),
			.out_data  (data_p[i+1])
		);
	end

	vaa_unfold u_unfold (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_p[vaa_pkg::ITERATIONS]),
		.in_ready  (ready_p[vaa_pkg::ITERATIONS]),
		.in_data   (data_p[vaa_pkg::ITERATIONS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.angle     (angle)
	);

	assign m_tdata = vaa_pkg::TDATA_OUT_W'(angle);

	// input back-pressure can only come from a full pipe behind a stalled output
	`VAA_ASSERT_IMP(a_stall_source, clk, arst_n,
		!s_tready, m_tvalid && !m_tready, "input stalled while the output was free")

	// a stalled input means the fold stage and the last micro-rotation both hold an item
	`VAA_ASSERT_IMP(a_pipe_full_ready, clk, arst_n,
		!s_tready, valid_p[0] && valid_p[vaa_pkg::ITERATIONS], "stall with an empty stage")

endmodule

@@ sv/vaa_fold.sv @@
// ----------------------------------------------------------------------------
// vaa_fold
// Input stage: folds the deflection into the first quadrant and scales it.
// ----------------------------------------------------------------------------
module vaa_fold (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [vaa_pkg::DEFL_W-1:0] dx,
	input  logic signed [vaa_pkg::DEFL_W-1:0] dy,
	output logic                           out_valid,
	input  logic                           out_ready,
	output vaa_pkg::cordic_t               out_data
);

	logic                         valid_s1;
	vaa_pkg::cordic_t             data_s1;
	vaa_pkg::cordic_t             fold_d;
	logic [vaa_pkg::MAG_W-1:0]    ax;
	logic [vaa_pkg::MAG_W-1:0]    ay;
	logic                         x_zero;
	logic                         y_zero;

	always_comb begin
		ax     = dx[vaa_pkg::DEFL_W-1] ? vaa_pkg::MAG_W'(-dx) : vaa_pkg::MAG_W'(dx);
		ay     = dy[vaa_pkg::DEFL_W-1] ? vaa_pkg::MAG_W'(-dy) : vaa_pkg::MAG_W'(dy);
		x_zero = (dx == '0);
		y_zero = (dy == '0);

		fold_d.x = signed'({3'b000, ax, {vaa_pkg::MAG_SHIFT{1'b0}}});
		fold_d.y = signed'({3'b000, ay, {vaa_pkg::MAG_SHIFT{1'b0}}});
		fold_d.z = '0;
		fold_d.route.axis = x_zero || y_zero;

		if (y_zero) begin
			// zero vector and +x both give 0
			fold_d.route.fold = dx[vaa_pkg::DEFL_W-1] ? vaa_pkg::FOLD_Q3 : vaa_pkg::FOLD_Q1;
		end else if (x_zero) begin
			fold_d.route.fold = dy[vaa_pkg::DEFL_W-1] ? vaa_pkg::FOLD_Q4 : vaa_pkg::FOLD_Q2;
		end else if (!dy[vaa_pkg::DEFL_W-1]) begin
			fold_d.route.fold = dx[vaa_pkg::DEFL_W-1] ? vaa_pkg::FOLD_Q2 : vaa_pkg::FOLD_Q1;
		end else begin
			fold_d.route.fold = dx[vaa_pkg::DEFL_W-1] ? vaa_pkg::FOLD_Q3 : vaa_pkg::FOLD_Q4;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= fold_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

@@ sv/vaa_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// vaa_cordic_stage
// One registered vectoring micro-rotation; the step number sets shift and angle.
// ----------------------------------------------------------------------------
module vaa_cordic_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [vaa_pkg::STEP_W-1:0]  step,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  vaa_pkg::cordic_t            in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output vaa_pkg::cordic_t            out_data
);

	logic                           valid_s1;
	vaa_pkg::cordic_t               data_s1;
	vaa_pkg::cordic_t               rot_d;
	logic signed [vaa_pkg::XY_W-1:0] xs;
	logic signed [vaa_pkg::XY_W-1:0] ys;
	logic signed [vaa_pkg::Z_W-1:0]  da;

	always_comb begin
		xs = in_data.x >>> step;
		ys = in_data.y >>> step;
		da = vaa_pkg::atan_step(step);
		rot_d.route = in_data.route;
		// rotate towards the x axis: clockwise while y is not negative
		if (!in_data.y[vaa_pkg::XY_W-1]) begin
			rot_d.x = in_data.x + ys;
			rot_d.y = in_data.y - xs;
			rot_d.z = in_data.z + da;
		end else begin
			rot_d.x = in_data.x - ys;
			rot_d.y = in_data.y + xs;
			rot_d.z = in_data.z - da;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= rot_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

@@ sv/vaa_unfold.sv @@
// ----------------------------------------------------------------------------
// vaa_unfold
// Output stage: clamps and rounds the angle, then maps it back to its quadrant.
// ----------------------------------------------------------------------------
`include "vector_angle_atan2_macros.svh"

module vaa_unfold (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  vaa_pkg::cordic_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [vaa_pkg::ANGLE_W-1:0]    angle
);

	logic                              valid_s1;
	logic [vaa_pkg::ANGLE_BITS-1:0]    angle_s1;
	logic [vaa_pkg::ZC_W-1:0]          zc;
	logic [vaa_pkg::ZC_W-1:0]          zr;
	logic [vaa_pkg::ANGLE_BITS-1:0]    q;
	logic [vaa_pkg::ANGLE_BITS-1:0]    a;

	always_comb begin
		if (in_data.z[vaa_pkg::Z_W-1]) begin
			zc = '0;
		end else if (in_data.z > signed'({2'b00, vaa_pkg::Z_QUARTER})) begin
			zc = vaa_pkg::Z_QUARTER;
		end else begin
			zc = vaa_pkg::ZC_W'(in_data.z);
		end
		zr = zc + vaa_pkg::ROUND_HALF;
		q  = vaa_pkg::ANGLE_BITS'(zr >> vaa_pkg::ROUND_SHIFT);

		if (in_data.route.axis) begin
			a = vaa_pkg::ANGLE_BITS'(in_data.route.fold) << (vaa_pkg::ANGLE_BITS - 2);
		end else begin
			case (in_data.route.fold)
				vaa_pkg::FOLD_Q1: a = q;
				vaa_pkg::FOLD_Q2: a = vaa_pkg::ANGLE_HALF - q;
				vaa_pkg::FOLD_Q3: a = vaa_pkg::ANGLE_HALF + q;
				default:          a = '0 - q;
			endcase
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			angle_s1 <= a;
		end
	end

	assign out_valid = valid_s1;
	assign angle     = vaa_pkg::ANGLE_W'(angle_s1);

	`VAA_ASSERT_NXT(a_zero_or_plus_x, clk, arst_n,
		in_valid && in_ready && in_data.route.axis && (in_data.route.fold == vaa_pkg::FOLD_Q1),
		valid_s1 && (angle_s1 == '0), "zero vector or +x axis did not give angle 0")

	`VAA_ASSERT_NXT(a_q1_in_range, clk, arst_n,
		in_valid && in_ready && !in_data.route.axis && (in_data.route.fold == vaa_pkg::FOLD_Q1),
		valid_s1 && (angle_s1 <= vaa_pkg::ANGLE_QUARTER), "first quadrant angle beyond a quarter turn")

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the vector angle block item by item against an in-line CORDIC angle
// predictor. Directed edge vectors come first, then random vectors across
// idle and stall phases, including one long output hold that fills the pipe.
// ----------------------------------------------------------------------------
module testbench;

	localparam int  HOLD_LEN    = 120;
	localparam int  DRAIN_WAIT  = vaa_pkg::ITERATIONS + 2 + 20;
	localparam int  CYCLE_LIMIT = 200000;
	localparam int  N_RANDOM    = 120;
	localparam int  N_PRESSURE  = 50;

	typedef struct packed {
		logic signed [vaa_pkg::DEFL_W-1:0] dy;
		logic signed [vaa_pkg::DEFL_W-1:0] dx;
	} deflection_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [vaa_pkg::TDATA_IN_W-1:0]  s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [vaa_pkg::TDATA_OUT_W-1:0] m_tdata;

	deflection_t                 vectors_pending[$];
	logic [vaa_pkg::ANGLE_W-1:0] angles_due[$];
	deflection_t                 next_vec;
	logic [vaa_pkg::ANGLE_W-1:0] want_angle;
	int                          send_idle_pct = 0;
	int                          recv_stall_pct = 0;
	int                          hold_req = 0;
	int                          hold_seen = 0;
	int                          hold_left = 0;
	int                          mismatches = 0;
	int                          cycle_count = 0;

	vector_angle_atan2 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// atan(2^-i) in units of 2^-32 turn
	function automatic longint micro_rot_angle(input int i);
		case (i)
			0:  return 64'h20000000;
			1:  return 64'h12E4051E;
			2:  return 64'h09FB385B;
			3:  return 64'h051111D4;
			4:  return 64'h028B0D43;
			5:  return 64'h0145D7E1;
			6:  return 64'h00A2F61E;
			7:  return 64'h00517C55;
			8:  return 64'h0028BE53;
			9:  return 64'h00145F2F;
			10: return 64'h000A2F98;
			11: return 64'h000517CC;
			12: return 64'h00028BE6;
			13: return 64'h000145F3;
			14: return 64'h0000A2FA;
			15: return 64'h0000517D;
			16: return 64'h000028BE;
			17: return 64'h0000145F;
			18: return 64'h00000A30;
			19: return 64'h00000518;
			20: return 64'h0000028C;
			21: return 64'h00000146;
			22: return 64'h000000A3;
			default: return 64'h00000051;
		endcase
	endfunction

	function automatic logic [vaa_pkg::ANGLE_W-1:0] predict_angle(
			input logic signed [vaa_pkg::DEFL_W-1:0] dx,
			input logic signed [vaa_pkg::DEFL_W-1:0] dy);
		longint          x, y, z, xs, ys;
		longint unsigned full_turn, half_turn, quarter_turn, q, a;
		int              shift;
		full_turn    = 64'd1 << vaa_pkg::ANGLE_BITS;
		half_turn    = full_turn >> 1;
		quarter_turn = full_turn >> 2;
		shift        = 32 - vaa_pkg::ANGLE_BITS;
		if (dx == 0 && dy == 0) begin
			a = 0;
		end else if (dy == 0) begin
			a = (dx > 0) ? 0 : half_turn;
		end else if (dx == 0) begin
			a = (dy > 0) ? quarter_turn : half_turn + quarter_turn;
		end else begin
			// fold into the first quadrant and scale up
			x = (dx < 0) ? -longint'(dx) : longint'(dx);
			y = (dy < 0) ? -longint'(dy) : longint'(dy);
			x = x * (64'sd1 << vaa_pkg::MAG_SHIFT);
			y = y * (64'sd1 << vaa_pkg::MAG_SHIFT);
			z = 0;
			for (int i = 0; i < vaa_pkg::ITERATIONS && i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + micro_rot_angle(i);
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - micro_rot_angle(i);
				end
			end
			if (z < 0)
				z = 0;
			if (z > (64'sd1 << 30))
				z = 64'sd1 << 30;
			q = (longint'(z) + (64'd1 << (shift - 1))) >> shift;
			if (dx > 0 && dy > 0)
				a = q;
			else if (dx < 0 && dy > 0)
				a = half_turn - q;
			else if (dx < 0)
				a = half_turn + q;
			else
				a = full_turn - q;
		end
		a = a & (full_turn - 1);
		return a[vaa_pkg::ANGLE_W-1:0];
	endfunction

	task automatic add_vector(input int dx, input int dy);
		deflection_t v;
		v.dx = dx[vaa_pkg::DEFL_W-1:0];
		v.dy = dy[vaa_pkg::DEFL_W-1:0];
		vectors_pending.push_back(v);
	endtask

	// mostly full-range vectors, with short ones, axis points and corners mixed in
	task automatic add_random(input int n);
		int r, dx, dy;
		int corner[6];
		corner = '{-2048, -2047, -1, 0, 1, 2047};
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 70) begin
				dx = $urandom;
				dy = $urandom;
			end else if (r < 85) begin
				dx = $urandom_range(15);
				dy = $urandom_range(15);
				if ($urandom_range(1))
					dx = -dx;
				if ($urandom_range(1))
					dy = -dy;
			end else if (r < 93) begin
				dx = $urandom;
				dy = 0;
				if ($urandom_range(1)) begin
					dy = dx;
					dx = 0;
				end
			end else begin
				dx = corner[$urandom_range(5)];
				dy = corner[$urandom_range(5)];
			end
			add_vector(dx, dy);
		end
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int n);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		add_random(n);
		while (vectors_pending.size() != 0)
			@(negedge clk);
	endtask

	// sender: offer the next vector or idle, hold while not taken
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				angles_due.push_back(predict_angle(s_tdata[vaa_pkg::DEFL_W-1:0],
					s_tdata[2*vaa_pkg::DEFL_W-1:vaa_pkg::DEFL_W]));
			if (!s_tvalid || s_tready) begin
				if (vectors_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_vec = vectors_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {next_vec.dy, next_vec.dx};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long output hold, started by a bump of hold_req
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (angles_due.size() == 0) begin
				$display("%0t: angle item with none due: expected none, got %0d",
					$time, m_tdata);
				mismatches++;
			end else begin
				want_angle = angles_due.pop_front();
				if (m_tdata !== want_angle) begin
					$display("%0t: angle mismatch: expected %0d, got %0d",
						$time, want_angle, m_tdata);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero vector, axis points, corners, near-axis and unit diagonals
		add_vector(0, 0);
		add_vector(2047, 0);
		add_vector(-2048, 0);
		add_vector(0, 2047);
		add_vector(0, -2048);
		add_vector(1, 0);
		add_vector(-1, 0);
		add_vector(0, 1);
		add_vector(0, -1);
		add_vector(2047, 2047);
		add_vector(-2048, 2047);
		add_vector(-2048, -2048);
		add_vector(2047, -2048);
		add_vector(1, 1);
		add_vector(-1, 1);
		add_vector(-1, -1);
		add_vector(1, -1);
		add_vector(2047, -1);
		add_vector(1, -2048);
		add_vector(2047, 1);
		add_vector(1, 2047);
		add_vector(-2048, 1);
		add_vector(-1, -2048);
		run_phase(0, 0, N_RANDOM);

		// hold the output while vectors keep coming, so the pipe fills
		@(negedge clk);
		hold_req = hold_req + 1;
		run_phase(0, 0, N_PRESSURE);

		run_phase(52, 0, N_RANDOM);
		run_phase(0, 52, N_RANDOM);
		run_phase(8, 8, N_RANDOM);

		while (s_tvalid || angles_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && angles_due.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

@@ vector_angle_atan2.f @@
+incdir+sv
sv/vaa_pkg.sv
sv/vaa_fold.sv
sv/vaa_cordic_stage.sv
sv/vaa_unfold.sv
sv/vector_angle_atan2.sv
tb/sv/testbench.sv
